FILE: design/isfg_pkg.sv
// Shared constants, widths and codes of the ideal sinc FIR tap generator.
package isfg_pkg;

    localparam int MAX_TAPS_DEF  = 256;
    localparam int COEF_BITS_DEF = 16;

    localparam int CORDIC_STEPS = 24;
    localparam int XW = 33;   // CORDIC x and y width
    localparam int ZW = 32;   // CORDIC angle width, 2^32 per turn
    localparam int JW = 11;   // signed doubled distance from the centre
    localparam int AW = 10;   // magnitude of that distance
    localparam int PW = 18;   // phase as a fraction of a turn
    localparam int DW = 18;   // signed centre fraction

    localparam logic signed [XW-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [XW-1:0] ONE_Q30     = 33'sd1073741824;
    localparam logic [31:0]          INV_PI_Q32  = 32'd1367130551;

    localparam logic [ZW-1:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum logic [1:0] {
        MODE_LOWPASS  = 2'd0,
        MODE_HIGHPASS = 2'd1,
        MODE_BANDPASS = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REG_MODE  = 2'd0,
        REG_COUNT = 2'd1,
        REG_LOWER = 2'd2,
        REG_UPPER = 2'd3
    } reg_index_t;

endpackage

FILE: design/isfg_in_if.sv
// Input channel: one tap index per word.
interface isfg_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] tap_index;

    modport source (output valid, output tap_index, input ready);
    modport sink   (input valid, input tap_index, output ready);
endinterface

FILE: design/isfg_out_if.sv
// Output channel: one coefficient and its tap index per word.
interface isfg_out_if #(
    parameter int COEF_BITS = isfg_pkg::COEF_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [COEF_BITS-1:0] tap_value;
    logic [7:0]                  index_out;

    modport source (output valid, output tap_value, output index_out, input ready);
    modport sink   (input valid, input tap_value, input index_out, output ready);
endinterface

FILE: design/isfg_cordic_cell.sv
// One rotation step of the pipelined CORDIC sine.
module isfg_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [isfg_pkg::XW-1:0] x_in,
    input  logic signed [isfg_pkg::XW-1:0] y_in,
    input  logic signed [isfg_pkg::ZW-1:0] z_in,
    output logic signed [isfg_pkg::XW-1:0] x_out,
    output logic signed [isfg_pkg::XW-1:0] y_out,
    output logic signed [isfg_pkg::ZW-1:0] z_out
);

    logic signed [isfg_pkg::XW-1:0] x_reg, y_reg, x_next, y_next, dx, dy;
    logic signed [isfg_pkg::ZW-1:0] z_reg, z_next, ang;

    always_comb
    begin
        dx  = y_in >>> STEP;
        dy  = x_in >>> STEP;
        ang = signed'(isfg_pkg::ATAN_TAB[STEP]);
        if (!z_in[isfg_pkg::ZW-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ang;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

FILE: design/isfg_div_cell.sv
// One quotient bit of the pipelined restoring divider.
module isfg_div_cell #(
    parameter int NUM_W = 18
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic [isfg_pkg::AW-1:0] rem_in,
    input  logic [NUM_W-1:0]        num_in,
    input  logic [NUM_W-1:0]        quo_in,
    input  logic [isfg_pkg::AW-1:0] div_in,
    output logic [isfg_pkg::AW-1:0] rem_out,
    output logic [NUM_W-1:0]        num_out,
    output logic [NUM_W-1:0]        quo_out,
    output logic [isfg_pkg::AW-1:0] div_out
);

    logic [isfg_pkg::AW:0]   trial;
    logic [isfg_pkg::AW:0]   diff;
    logic                    take;
    logic [isfg_pkg::AW-1:0] rem_reg, rem_next, div_reg;
    logic [NUM_W-1:0]        num_reg, quo_reg;

    always_comb
    begin
        trial    = {rem_in, num_in[NUM_W-1]};
        diff     = trial - {1'b0, div_in};
        take     = (trial >= {1'b0, div_in});
        rem_next = take ? diff[isfg_pkg::AW-1:0] : trial[isfg_pkg::AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_in[NUM_W-2:0], 1'b0};
            quo_reg <= {quo_in[NUM_W-2:0], take};
            div_reg <= div_in;
        end
    end

    assign rem_out = rem_reg;
    assign num_out = num_reg;
    assign quo_out = quo_reg;
    assign div_out = div_reg;

endmodule

FILE: design/ideal_sinc_fir_tap_generator.sv
// Top level of the ideal sinc FIR tap generator.
//
//  channel   direction  word
//  tap_in    in         tap_index[7:0]
//  tap_out   out        tap_value[COEF_BITS-1:0] signed, index_out[7:0]
//  cfg       in         cfg_we, cfg_index[1:0], cfg_data[15:0], no handshake
//
// One word is taken per cycle while the skid register is empty. The chain holds two front stages,
// 24 CORDIC cells, four scaling stages, one divider cell per quotient bit, output register.
// Reset sets the configuration registers to their defaults and empties every stage.
// When the output stalls, a skid register catches the word in flight and the whole
// chain holds until the skid register drains.
module ideal_sinc_fir_tap_generator #(
    parameter int MAX_TAPS  = isfg_pkg::MAX_TAPS_DEF,
    parameter int COEF_BITS = isfg_pkg::COEF_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    isfg_in_if.sink           tap_in,
    isfg_out_if.source        tap_out
);

    localparam int F     = COEF_BITS - 1;
    localparam int SH    = 61 - F;
    localparam int NUM_W = 64 - SH;
    localparam int CW    = isfg_pkg::DW + COEF_BITS;
    localparam int NS    = isfg_pkg::CORDIC_STEPS;
    localparam int XW    = isfg_pkg::XW;
    localparam int ZW    = isfg_pkg::ZW;
    localparam int JW    = isfg_pkg::JW;
    localparam int AW    = isfg_pkg::AW;
    localparam int PW    = isfg_pkg::PW;
    localparam int DW    = isfg_pkg::DW;

    localparam logic signed [CW-1:0] C_HI = CW'((64'sd1 <<< F) - 64'sd1);
    localparam logic signed [CW-1:0] C_LO = CW'(-(64'sd1 <<< F));
    localparam logic [NUM_W-1:0] CAP = NUM_W'(64'd1 << F);

    typedef struct packed {
        logic                        valid;
        logic [7:0]                  idx;
        logic signed [JW-1:0]        j;
        logic signed [COEF_BITS-1:0] centre;
        logic [1:0]                  qa;
        logic [1:0]                  qb;
    } front_t;

    typedef struct packed {
        logic                        valid;
        logic [7:0]                  idx;
        logic                        neg;
        logic                        zero;
        logic signed [COEF_BITS-1:0] centre;
    } back_t;

    // Configuration registers.
    logic [1:0]  mode_reg;
    logic [8:0]  count_reg;
    logic [15:0] lower_reg, upper_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= isfg_pkg::MODE_LOWPASS;
            count_reg <= 9'd63;
            lower_reg <= 16'd16384;
            upper_reg <= 16'd32768;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                isfg_pkg::REG_MODE:  mode_reg <= cfg_data[1:0];
                isfg_pkg::REG_COUNT:
                begin
                    if (int'(cfg_data[8:0]) > MAX_TAPS)
                        count_reg <= 9'(MAX_TAPS);
                    else
                        count_reg <= cfg_data[8:0];
                end
                isfg_pkg::REG_LOWER: lower_reg <= cfg_data;
                isfg_pkg::REG_UPPER: upper_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic skid_valid_reg;
    assign en = !skid_valid_reg;
    assign tap_in.ready = en;

    // Stage A: distance from the centre and the centre coefficient.
    logic [JW-1:0]               j_next;
    logic signed [DW-1:0]        d_next;
    logic signed [CW-1:0]        c_wide;
    logic signed [COEF_BITS-1:0] centre_next;
    front_t                      sa_reg;

    always_comb
    begin
        case (mode_reg)
            isfg_pkg::MODE_LOWPASS:
            begin
                j_next = {2'b00, tap_in.tap_index, 1'b0} - {2'b00, count_reg[8:1], 1'b0};
                d_next = signed'({2'b00, lower_reg});
            end
            isfg_pkg::MODE_HIGHPASS:
            begin
                j_next = {2'b00, tap_in.tap_index, 1'b0} - {2'b00, count_reg} + JW'(1);
                d_next = 18'sd65536 - signed'({2'b00, lower_reg});
            end
            default:
            begin
                j_next = {2'b00, tap_in.tap_index, 1'b0} - {2'b00, count_reg} + JW'(1);
                d_next = signed'({2'b00, upper_reg}) - signed'({2'b00, lower_reg});
            end
        endcase
        c_wide = ((signed'({{COEF_BITS{d_next[DW-1]}}, d_next}) <<< F) + CW'(32768)) >>> 16;
        if (c_wide > C_HI)
            centre_next = C_HI[COEF_BITS-1:0];
        else if (c_wide < C_LO)
            centre_next = C_LO[COEF_BITS-1:0];
        else
            centre_next = c_wide[COEF_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sa_reg <= '0;
        else if (en)
        begin
            sa_reg.valid  <= tap_in.valid;
            sa_reg.idx    <= tap_in.tap_index;
            sa_reg.j      <= signed'(j_next);
            sa_reg.centre <= centre_next;
            sa_reg.qa     <= 2'b00;
            sa_reg.qb     <= 2'b00;
        end
    end

    // Stage B: phases of both edges as fractions of a turn.
    logic [PW-1:0]   jx;
    logic [2*PW-1:0] prod_a, prod_b;
    front_t          side_in;
    front_t          side_reg [0:NS];
    logic signed [XW-1:0] cx [0:1][0:NS];
    logic signed [XW-1:0] cy [0:1][0:NS];
    logic signed [ZW-1:0] cz [0:1][0:NS];
    logic [ZW-1:0]        z0_a_reg, z0_b_reg;

    always_comb
    begin
        jx         = {{(PW-JW){sa_reg.j[JW-1]}}, sa_reg.j};
        prod_a     = jx * {2'b00, lower_reg};
        prod_b     = jx * {2'b00, upper_reg};
        side_in    = sa_reg;
        side_in.qa = prod_a[PW-1:PW-2];
        side_in.qb = prod_b[PW-1:PW-2];
    end

    // The side registers travel beside the stage B registers and the CORDIC cells, one per cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NS; s++)
                side_reg[s] <= '0;
        end
        else if (en)
        begin
            side_reg[0] <= side_in;
            for (int s = 0; s < NS; s++)
                side_reg[s+1] <= side_reg[s];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_a_reg <= {2'b00, prod_a[PW-3:0], 14'b0};
            z0_b_reg <= {2'b00, prod_b[PW-3:0], 14'b0};
        end
    end

    assign cx[0][0] = isfg_pkg::CORDIC_GAIN;
    assign cy[0][0] = '0;
    assign cz[0][0] = signed'(z0_a_reg);
    assign cx[1][0] = isfg_pkg::CORDIC_GAIN;
    assign cy[1][0] = '0;
    assign cz[1][0] = signed'(z0_b_reg);

    // CORDIC chain, one lane per edge.
    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        for (genvar s = 0; s < NS; s++)
        begin : g_step
            isfg_cordic_cell #(.STEP(s)) u_cell (
                .clk   (clk),
                .en    (en),
                .x_in  (cx[l][s]),
                .y_in  (cy[l][s]),
                .z_in  (cz[l][s]),
                .x_out (cx[l][s+1]),
                .y_out (cy[l][s+1]),
                .z_out (cz[l][s+1])
            );
        end
    end

    // Stage C: quadrant fold, clamp and the combined sine term.
    function automatic logic signed [XW-1:0] fold(input logic signed [XW-1:0] x,
                                                  input logic signed [XW-1:0] y,
                                                  input logic [1:0] q);
        logic signed [XW-1:0] v;
        v = q[0] ? x : y;
        if (v > isfg_pkg::ONE_Q30)
            v = isfg_pkg::ONE_Q30;
        if (v < -isfg_pkg::ONE_Q30)
            v = -isfg_pkg::ONE_Q30;
        return q[1] ? -v : v;
    endfunction

    logic signed [XW-1:0] sin_a, sin_b, s_next, s_reg;
    front_t               sc_reg;

    always_comb
    begin
        sin_a = fold(cx[0][NS], cy[0][NS], side_reg[NS].qa);
        sin_b = fold(cx[1][NS], cy[1][NS], side_reg[NS].qb);
        case (mode_reg)
            isfg_pkg::MODE_LOWPASS:  s_next = sin_a;
            isfg_pkg::MODE_HIGHPASS: s_next = -sin_a;
            default:                 s_next = sin_b - sin_a;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_reg <= '0;
        else if (en)
            sc_reg <= side_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s_reg <= s_next;
    end

    // Stage D: magnitudes and sign of the ratio.
    logic [XW-1:0] s_abs;
    logic [JW-1:0] j_abs;
    logic [31:0]   mag_reg;
    logic [AW-1:0] aj_d_reg, aj_e_reg, aj_f_reg;
    back_t         sd_reg, se_reg, dv_reg [0:NUM_W];

    always_comb
    begin
        s_abs = s_reg[XW-1] ? unsigned'(-s_reg) : unsigned'(s_reg);
        j_abs = sc_reg.j[JW-1] ? unsigned'(-sc_reg.j) : unsigned'(sc_reg.j);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sd_reg <= '0;
        else if (en)
        begin
            sd_reg.valid  <= sc_reg.valid;
            sd_reg.idx    <= sc_reg.idx;
            sd_reg.neg    <= s_reg[XW-1] ^ sc_reg.j[JW-1];
            sd_reg.zero   <= (sc_reg.j == '0);
            sd_reg.centre <= sc_reg.centre;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg  <= s_abs[31:0];
            aj_d_reg <= j_abs[AW-1:0];
        end
    end

    // Stage E: scale by 1/pi.
    logic [62:0] prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            se_reg <= '0;
        else if (en)
            se_reg <= sd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= {31'b0, mag_reg} * {31'b0, isfg_pkg::INV_PI_Q32};
            aj_e_reg <= aj_d_reg;
        end
    end

    // Stage F: add half the divisor for rounding, keep the dividend bits.
    logic [63:0]      m_sum;
    logic [NUM_W-1:0] num_reg;

    assign m_sum = {1'b0, prod_reg} + (64'(aj_e_reg) << (SH - 1));

    // The control words travel beside the stage F registers and the divider cells, one per cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NUM_W; s++)
                dv_reg[s] <= '0;
        end
        else if (en)
        begin
            dv_reg[0] <= se_reg;
            for (int s = 0; s < NUM_W; s++)
                dv_reg[s+1] <= dv_reg[s];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= m_sum[63:SH];
            aj_f_reg <= aj_e_reg;
        end
    end

    // Divider chain, one quotient bit per cell.
    logic [AW-1:0]    rem_w [0:NUM_W];
    logic [NUM_W-1:0] num_w [0:NUM_W];
    logic [NUM_W-1:0] quo_w [0:NUM_W];
    logic [AW-1:0]    div_w [0:NUM_W];

    assign rem_w[0] = '0;
    assign num_w[0] = num_reg;
    assign quo_w[0] = '0;
    assign div_w[0] = aj_f_reg;

    for (genvar s = 0; s < NUM_W; s++)
    begin : g_div
        isfg_div_cell #(.NUM_W(NUM_W)) u_cell (
            .clk     (clk),
            .en      (en),
            .rem_in  (rem_w[s]),
            .num_in  (num_w[s]),
            .quo_in  (quo_w[s]),
            .div_in  (div_w[s]),
            .rem_out (rem_w[s+1]),
            .num_out (num_w[s+1]),
            .quo_out (quo_w[s+1]),
            .div_out (div_w[s+1])
        );
    end

    // Final sign, cap and saturation; the centre tap takes its own value.
    logic [COEF_BITS-1:0]        q_cap;
    logic signed [COEF_BITS:0]   q_signed;
    logic signed [COEF_BITS-1:0] fin_value;
    back_t                       fin;

    always_comb
    begin
        fin = dv_reg[NUM_W];
        if (quo_w[NUM_W] > CAP)
            q_cap = CAP[COEF_BITS-1:0];
        else
            q_cap = quo_w[NUM_W][COEF_BITS-1:0];
        q_signed = fin.neg ? -signed'({1'b0, q_cap}) : signed'({1'b0, q_cap});
        if (fin.zero)
            fin_value = fin.centre;
        else if (!fin.neg && q_cap == CAP[COEF_BITS-1:0])
            fin_value = C_HI[COEF_BITS-1:0];
        else
            fin_value = q_signed[COEF_BITS-1:0];
    end

    // Output register with a skid register behind it.
    logic                        out_valid_reg;
    logic signed [COEF_BITS-1:0] out_value_reg, skid_value_reg;
    logic [7:0]                  out_idx_reg, skid_idx_reg;
    logic                        load_out, load_skid;

    always_comb
    begin
        load_out  = 1'b0;
        load_skid = 1'b0;
        if (skid_valid_reg)
            load_out = 1'b0;
        else if (fin.valid)
        begin
            if (!out_valid_reg || tap_out.ready)
                load_out = 1'b1;
            else
                load_skid = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (tap_out.ready)
                skid_valid_reg <= 1'b0;
        end
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (load_skid)
            skid_valid_reg <= 1'b1;
        else if (tap_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && tap_out.ready)
        begin
            out_value_reg <= skid_value_reg;
            out_idx_reg   <= skid_idx_reg;
        end
        else if (load_out)
        begin
            out_value_reg <= fin_value;
            out_idx_reg   <= fin.idx;
        end
        if (load_skid)
        begin
            skid_value_reg <= fin_value;
            skid_idx_reg   <= fin.idx;
        end
    end

    assign tap_out.valid     = out_valid_reg;
    assign tap_out.tap_value = out_value_reg;
    assign tap_out.index_out = out_idx_reg;

endmodule
